/* rtl/text_console_writer_macros.svh */
// Assertion macros used by the console writer top level.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcw_pkg.sv */
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE = 2'd2;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic [7:0] chr;
        logic [7:0] attr;
    } t_cell;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } t_request;

    typedef struct packed {
        t_cell      cell_data;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } t_result;

    typedef struct packed {
        logic start;
        logic res_ready;
    } t_seq_cmd;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_status;

endpackage

`default_nettype wire

/* rtl/tcw_cell_ram.sv */
// Cell store: one write port and one registered read port.
`default_nettype none

module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  tcw_pkg::t_cell      i_wdata,
    input  wire [AW-1:0]        i_raddr,
    output tcw_pkg::t_cell      o_rdata
);

    tcw_pkg::t_cell r_mem [DEPTH];
    tcw_pkg::t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/tcw_seq.sv */
// Sequencer of the console: cursor, clearing pass, scroll copy and cell access.
`default_nettype none

module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tcw_pkg::t_seq_cmd    i_cmd,
    input  tcw_pkg::t_request    i_req,
    input  wire [7:0]            i_attr,
    output tcw_pkg::t_seq_status o_status,
    output tcw_pkg::t_result     o_result,
    output logic                 o_ram_we,
    output logic [AW-1:0]        o_ram_waddr,
    output tcw_pkg::t_cell       o_ram_wdata,
    output logic [AW-1:0]        o_ram_raddr,
    input  tcw_pkg::t_cell       i_ram_rdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_PUT   = 7'b0001000,
        S_COPY  = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state,   n_state;
    logic [CW-1:0]     r_col,     n_col;
    logic [RW-1:0]     r_row,     n_row;
    logic [CNTW-1:0]   r_addr,    n_addr;
    logic [AW-1:0]     r_cp_addr, n_cp_addr;
    logic              r_cp_valid, n_cp_valid;
    logic              r_put,     n_put;
    logic              r_scr,     n_scr;
    logic              r_rd_ok,   n_rd_ok;
    logic [7:0]        r_char,    n_char;
    tcw_pkg::t_cell    r_cell,    n_cell;

    logic              row_last;
    logic              rd_ok;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     cur_addr;

    assign row_last = (r_row == RW'(ROWS - 1));
    assign rd_ok    = (32'(i_req.read_col) < COLUMNS) && (32'(i_req.read_row) < ROWS);
    assign rd_addr  = AW'(32'(i_req.read_row) * COLUMNS + 32'(i_req.read_col));
    assign cur_addr = AW'(32'(r_row) * COLUMNS + 32'(r_col));

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_addr     = r_addr;
        n_cp_addr  = r_cp_addr;
        n_cp_valid = r_cp_valid;
        n_put      = r_put;
        n_scr      = r_scr;
        n_rd_ok    = r_rd_ok;
        n_char     = r_char;
        n_cell     = r_cell;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr[AW-1:0];
        o_ram_wdata = '{chr: tcw_pkg::BLANK_CODE, attr: i_attr};
        o_ram_raddr = r_addr[AW-1:0];

        case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = '{chr: tcw_pkg::BLANK_CODE, attr: tcw_pkg::RESET_ATTR};
                if (r_addr == CNTW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                o_ram_raddr = rd_addr;
                if (i_cmd.start) begin
                    n_scr  = 1'b0;
                    n_cell = '0;
                    n_char = i_req.char_code;
                    if (i_req.mode == tcw_pkg::MODE_READ) begin
                        n_rd_ok = rd_ok;
                        n_state = S_READ;
                    end else if (i_req.char_code == tcw_pkg::NEWLINE_CODE ||
                                 r_col == CW'(COLUMNS)) begin
                        // Newline, or a character that meets a pending wrap.
                        n_col = '0;
                        n_put = (i_req.char_code != tcw_pkg::NEWLINE_CODE);
                        if (row_last) begin
                            n_scr      = 1'b1;
                            n_addr     = CNTW'(COLUMNS);
                            n_cp_valid = 1'b0;
                            n_state    = S_COPY;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_state = n_put ? S_PUT : S_DONE;
                        end
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_READ: begin
                n_cell  = r_rd_ok ? i_ram_rdata : '0;
                n_state = S_DONE;
            end
            S_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = cur_addr;
                o_ram_wdata = '{chr: r_char, attr: i_attr};
                n_col       = r_col + 1'b1;
                n_state     = S_DONE;
            end
            S_COPY: begin
                // Read one cell per cycle and write it a row higher in the next cycle.
                o_ram_we    = r_cp_valid;
                o_ram_waddr = r_cp_addr;
                o_ram_wdata = i_ram_rdata;
                n_cp_addr   = AW'(r_addr - CNTW'(COLUMNS));
                n_cp_valid  = 1'b1;
                if (r_addr == CNTW'(CELLS)) begin
                    n_cp_valid = 1'b0;
                    n_addr     = CNTW'(CELLS - COLUMNS);
                    n_state    = S_FILL;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FILL: begin
                o_ram_we = 1'b1;
                if (r_addr == CNTW'(CELLS - 1)) begin
                    n_state = r_put ? S_PUT : S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                if (i_cmd.res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_col      <= '0;
            r_row      <= '0;
            r_addr     <= '0;
            r_cp_valid <= 1'b0;
            r_put      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_addr     <= n_addr;
            r_cp_valid <= n_cp_valid;
            r_put      <= n_put;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        r_scr     <= n_scr;
        r_rd_ok   <= n_rd_ok;
        r_char    <= n_char;
        r_cell    <= n_cell;
    end

    assign o_status.idle      = (r_state == S_IDLE);
    assign o_status.res_valid = (r_state == S_DONE);

    assign o_result.cell_data  = r_cell;
    assign o_result.cursor_col = 7'(r_col);
    assign o_result.cursor_row = 5'(r_row);
    assign o_result.scrolled   = r_scr;

endmodule

`default_nettype wire

/* rtl/text_console_writer.sv */
// Top level of the text console writer: stream ports, color registers, result register.
//
// Requests arrive on the slave stream: tuser carries the mode (0 put, 1 read)
// and tdata carries the character code, read column and read row. Every request
// produces exactly one response on the master stream carrying the read cell
// (zero for a put), the cursor after the request and a scroll flag.
// Color registers are written through the plain write port, by the user only while the
// block is idle, which is not enforced; written cells take the packed attribute.
// One request is handled at a time. A request that scrolls first copies the
// cells one row up, one cell per cycle, reading and writing the cell store
// through its read and write ports together, then blanks the bottom row.
// After reset a clearing pass writes all COLUMNS*ROWS cells blank with
// attribute 0x07; no request is accepted until it is done, though color
// register writes are taken. The response waits in an output register while
// the receiver stalls; the sequencer holds its finished response until that
// register frees, and only then takes the next request.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] char_code, [14:8] read_col, [19:15] read_row, [23:20] zero
    input  wire [23:0]                      i_s_axis_tdata,
    // [0] mode
    input  wire                             i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row,
    // [28] scrolled, [31:29] zero
    output logic [31:0]                     o_m_axis_tdata,
    input  wire                             i_cfg_wen,
    input  wire [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

`include "text_console_writer_macros.svh"

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [3:0]            r_fg;
    logic [2:0]            r_bg;
    logic                  r_blink;
    logic [7:0]            attr;

    logic                  r_out_valid, n_out_valid;
    tcw_pkg::t_result      r_out;

    tcw_pkg::t_request     req;
    tcw_pkg::t_seq_cmd     cmd;
    tcw_pkg::t_seq_status  status;
    tcw_pkg::t_result      result;
    logic                  load;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    tcw_pkg::t_cell        ram_wdata;
    tcw_pkg::t_cell        ram_rdata;

    // Color registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg    <= 4'd7;
            r_bg    <= 3'd0;
            r_blink <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                tcw_pkg::REG_FG_COLOR:     r_fg    <= i_cfg_wdata[3:0];
                tcw_pkg::REG_BG_COLOR:     r_bg    <= i_cfg_wdata[2:0];
                tcw_pkg::REG_BLINK_ENABLE: r_blink <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign attr = {r_blink, r_bg, r_fg};

    assign req.mode      = i_s_axis_tuser;
    assign req.char_code = i_s_axis_tdata[7:0];
    assign req.read_col  = i_s_axis_tdata[14:8];
    assign req.read_row  = i_s_axis_tdata[19:15];

    // The sequencer only takes a request from its idle state.
    assign o_s_axis_tready = status.idle;
    assign cmd.start       = i_s_axis_tvalid && status.idle;
    assign cmd.res_ready   = !r_out_valid || i_m_axis_tready;
    assign load            = status.res_valid && cmd.res_ready;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (req),
        .i_attr      (attr),
        .o_status    (status),
        .o_result    (result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register: holds a response while the receiver stalls.
    assign n_out_valid = load || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.scrolled, r_out.cursor_row, r_out.cursor_col,
                              r_out.cell_data.attr, r_out.cell_data.chr};

    // An accepted request moves the sequencer out of idle, so tready drops.
    `TCW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
        "request accepted but block ready again at once")

    // A scrolling step always leaves the cursor on the bottom row.
    `TCW_ASSERT_SAME(a_scroll_bottom_row, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[28],
        o_m_axis_tdata[27:23] == 5'(ROWS - 1),
        "scroll reported with cursor off the bottom row")

    // A response is only loaded into a free or draining output register.
    `TCW_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n,
        load, !r_out_valid || i_m_axis_tready,
        "pending response overwritten")

endmodule

`default_nettype wire
